@@ rtl/core/rag_pkg.sv @@
package rag_pkg;

   // Address and multiplier operand widths
   localparam int ADDR_W = 36;
   localparam int OPND_W = 16;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_BATCH_COUNT   = 3'd0,
      REG_CHANNEL_COUNT = 3'd1,
      REG_HEIGHT_COUNT  = 3'd2,
      REG_WIDTH_COUNT   = 3'd3,
      REG_BLOCK_STRIDE  = 3'd4,
      REG_DIRECTION     = 3'd5,
      REG_CHANNELS_LAST = 3'd6
   } reg_index_type;

   // Operands of a0 + m0 * (a1 + m1 * (a2 + m2 * a3))
   typedef struct packed {
      logic [OPND_W-1:0] a0;
      logic [OPND_W-1:0] m0;
      logic [OPND_W-1:0] a1;
      logic [OPND_W-1:0] m1;
      logic [OPND_W-1:0] a2;
      logic [OPND_W-1:0] m2;
      logic [OPND_W-1:0] a3;
   } horner_type;

endpackage

@@ rtl/core/rag_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module rag_div #(
   parameter int NUM_W = 12,
   parameter int DEN_W = 4,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [DEN_W-1:0] out_rem,
   output logic [PAY_W-1:0] out_pay
);

   logic             vld_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] quo_ff [NUM_W];
   logic [DEN_W-1:0] den_ff [NUM_W];
   logic [PAY_W-1:0] pay_ff [NUM_W];

   for (genvar t = 0; t < NUM_W; t++) begin : g_step
      logic             vld_src;
      logic [DEN_W-1:0] rem_src;
      logic [NUM_W-1:0] quo_src;
      logic [DEN_W-1:0] den_src;
      logic [PAY_W-1:0] pay_src;
      logic [DEN_W:0]   part;
      logic [DEN_W:0]   diff;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      logic [NUM_W-1:0] quo_in;

      if (t == 0) begin : g_first
         assign vld_src = in_valid;
         assign rem_src = '0;
         assign quo_src = in_num;
         assign den_src = in_den;
         assign pay_src = in_pay;
      end else begin : g_next
         assign vld_src = vld_ff[t-1];
         assign rem_src = rem_ff[t-1];
         assign quo_src = quo_ff[t-1];
         assign den_src = den_ff[t-1];
         assign pay_src = pay_ff[t-1];
      end

      // shift next dividend bit into the partial remainder, subtract if it fits
      assign part   = {rem_src, quo_src[NUM_W-1]};
      assign diff   = part - {1'b0, den_src};
      assign take   = (part >= {1'b0, den_src});
      assign rem_in = take ? diff[DEN_W-1:0] : part[DEN_W-1:0];
      assign quo_in = {quo_src[NUM_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[t] <= 1'b0;
         end else if (advance) begin
            vld_ff[t] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[t] <= rem_in;
            quo_ff[t] <= quo_in;
            den_ff[t] <= den_src;
            pay_ff[t] <= pay_src;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_rem   = rem_ff[NUM_W-1];
   assign out_pay   = pay_ff[NUM_W-1];

endmodule

@@ rtl/core/rag_mac.sv @@
// Three-stage Horner chain: a0 + m0 * (a1 + m1 * (a2 + m2 * a3)) mod 2^ADDR_W.
module rag_mac (
   input  logic                       clock,
   input  logic                       advance,
   input  rag_pkg::horner_type        in_opnd,
   output logic [rag_pkg::ADDR_W-1:0] out_result
);

   localparam int AW = rag_pkg::ADDR_W;
   localparam int OW = rag_pkg::OPND_W;

   logic [2*OW-1:0] prod1;
   logic [AW-1:0]   prod2;
   logic [AW-1:0]   prod3;
   logic [AW-1:0]   r1_in;
   logic [AW-1:0]   r2_in;
   logic [AW-1:0]   r3_in;
   logic [AW-1:0]   r1_ff;
   logic [AW-1:0]   r2_ff;
   logic [AW-1:0]   r3_ff;
   logic [OW-1:0]   a1_ff;
   logic [OW-1:0]   m1_ff;
   logic [OW-1:0]   a0_s1_ff;
   logic [OW-1:0]   m0_s1_ff;
   logic [OW-1:0]   a0_s2_ff;
   logic [OW-1:0]   m0_s2_ff;

   assign prod1 = in_opnd.m2 * in_opnd.a3;
   assign r1_in = AW'(prod1) + AW'(in_opnd.a2);
   assign prod2 = AW'(m1_ff) * r1_ff;
   assign r2_in = prod2 + AW'(a1_ff);
   assign prod3 = AW'(m0_s2_ff) * r2_ff;
   assign r3_in = prod3 + AW'(a0_s2_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_ff    <= r1_in;
         a1_ff    <= in_opnd.a1;
         m1_ff    <= in_opnd.m1;
         a0_s1_ff <= in_opnd.a0;
         m0_s1_ff <= in_opnd.m0;
         r2_ff    <= r2_in;
         a0_s2_ff <= a0_s1_ff;
         m0_s2_ff <= m0_s1_ff;
         r3_ff    <= r3_in;
      end
   end

   assign out_result = r3_ff;

endmodule

@@ rtl/core/reorg_address_generator.sv @@
// Reorg (space-to-depth / depth-to-space) address generator.
// The pipe is stage A, the chain of three bit-serial divider pipelines
// (13 + 12 + 12 stages), stage C, the 3-stage multiply chain and the output register.
// Throughput: one request per cycle; a stall on rsp freezes the whole pipe.
// Reset: synchronous, clears all valid bits and loads register defaults
// (batch 1, channels 4, height 1, width 1, stride 2, direction 0, planar).
module reorg_address_generator #(
   parameter int MAX_CHANNELS = 4096,
   parameter int MAX_SIDE     = 1024,
   parameter int MAX_BATCH    = 16,
   parameter int MAX_STRIDE   = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // batch_index[3:0], channel_index[15:4],
                                    // row_index[25:16], column_index[35:26], zero pad
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // read_address[35:0], write_address[71:36]
   output logic        rsp_tuser,   // bad_request
   // register write port
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_addr,
   input  logic [12:0] csr_wdata
);

   localparam int AW = rag_pkg::ADDR_W;
   localparam int OW = rag_pkg::OPND_W;

   // request fields carried through the divider chain
   typedef struct packed {
      logic        bad;
      logic [3:0]  b;
      logic [11:0] k;
      logic [9:0]  j;
      logic [9:0]  i;
   } req_type;

   typedef struct packed {
      req_type     req;
      logic [12:0] oc;
   } oc_type;

   typedef struct packed {
      oc_type      prev;
      logic [12:0] c2;
   } chan_type;

   // ---------------- configuration registers ----------------
   logic [4:0]  batch_count_ff;
   logic [12:0] channel_count_ff;
   logic [10:0] height_count_ff;
   logic [10:0] width_count_ff;
   logic [3:0]  block_stride_ff;
   logic        direction_ff;
   logic        channels_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_count_ff   <= 5'd1;
         channel_count_ff <= 13'd4;
         height_count_ff  <= 11'd1;
         width_count_ff   <= 11'd1;
         block_stride_ff  <= 4'd2;
         direction_ff     <= 1'b0;
         channels_last_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (rag_pkg::reg_index_type'(csr_addr))
            rag_pkg::REG_BATCH_COUNT:   batch_count_ff   <= csr_wdata[4:0];
            rag_pkg::REG_CHANNEL_COUNT: channel_count_ff <= csr_wdata;
            rag_pkg::REG_HEIGHT_COUNT:  height_count_ff  <= csr_wdata[10:0];
            rag_pkg::REG_WIDTH_COUNT:   width_count_ff   <= csr_wdata[10:0];
            rag_pkg::REG_BLOCK_STRIDE:  block_stride_ff  <= csr_wdata[3:0];
            rag_pkg::REG_DIRECTION:     direction_ff     <= csr_wdata[0];
            rag_pkg::REG_CHANNELS_LAST: channels_last_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Derived sizes, refreshed every cycle. Registers are to change only while the
   // pipe is empty (the block does not enforce this), so these settle before any request reaches them.
   logic [7:0]  sq_ff;   // stride squared
   logic [14:0] ws_ff;   // spatial width
   logic [14:0] hs_ff;   // spatial height

   always_ff @(posedge clock) begin
      sq_ff <= 8'(block_stride_ff) * 8'(block_stride_ff);
      ws_ff <= 15'(width_count_ff) * 15'(block_stride_ff);
      hs_ff <= 15'(height_count_ff) * 15'(block_stride_ff);
   end

   // ---------------- flow control ----------------
   // Single global enable: every stage moves when the output slot is free
   // or being drained.
   logic advance;
   logic rsp_valid_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // ---------------- stage A: request register ----------------
   logic        a_vld_ff;
   logic [3:0]  a_b_ff;
   logic [11:0] a_k_ff;
   logic [9:0]  a_j_ff;
   logic [9:0]  a_i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (advance) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) begin
         a_b_ff <= req_tdata[3:0];
         a_k_ff <= req_tdata[15:4];
         a_j_ff <= req_tdata[25:16];
         a_i_ff <= req_tdata[35:26];
      end
   end

   // reject: no output channels, index out of range, or register above limit
   logic    bad_cfg;
   logic    bad_idx;
   req_type d1_in_pay;

   assign bad_cfg = (sq_ff == 8'd0) || (channel_count_ff < 13'(sq_ff))
                 || (32'(batch_count_ff) > MAX_BATCH)
                 || (32'(channel_count_ff) > MAX_CHANNELS)
                 || (32'(height_count_ff) > MAX_SIDE)
                 || (32'(width_count_ff) > MAX_SIDE)
                 || (32'(block_stride_ff) > MAX_STRIDE);
   assign bad_idx = ({1'b0, a_b_ff} >= batch_count_ff)
                 || ({1'b0, a_k_ff} >= channel_count_ff)
                 || ({1'b0, a_j_ff} >= height_count_ff)
                 || ({1'b0, a_i_ff} >= width_count_ff);

   assign d1_in_pay = '{bad: bad_cfg || bad_idx, b: a_b_ff, k: a_k_ff, j: a_j_ff, i: a_i_ff};

   // ---------------- divider 1: oc = channels / stride^2 ----------------
   logic        d1_vld;
   logic [12:0] d1_oc;
   req_type     d1_pay;

   rag_div #(.NUM_W(13), .DEN_W(8), .PAY_W($bits(req_type))) u_div_oc (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (a_vld_ff),
      .in_num    (channel_count_ff),
      .in_den    (sq_ff),
      .in_pay    (d1_in_pay),
      .out_valid (d1_vld),
      .out_quo   (d1_oc),
      .out_rem   (),
      .out_pay   (d1_pay)
   );

   // ---------------- divider 2: channel -> block offset, spatial channel ----------------
   logic        d2_vld;
   logic [11:0] d2_off;
   logic [12:0] d2_c2;
   oc_type      d2_in_pay;
   oc_type      d2_pay;

   assign d2_in_pay = '{req: d1_pay, oc: d1_oc};

   rag_div #(.NUM_W(12), .DEN_W(13), .PAY_W($bits(oc_type))) u_div_chan (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d1_vld),
      .in_num    (d1_pay.k),
      .in_den    (d1_oc),
      .in_pay    (d2_in_pay),
      .out_valid (d2_vld),
      .out_quo   (d2_off),
      .out_rem   (d2_c2),
      .out_pay   (d2_pay)
   );

   // ---------------- divider 3: offset -> row and column offsets ----------------
   logic        d3_vld;
   logic [11:0] d3_off_row;
   logic [3:0]  d3_off_col;
   chan_type    d3_in_pay;
   chan_type    d3_pay;

   assign d3_in_pay = '{prev: d2_pay, c2: d2_c2};

   rag_div #(.NUM_W(12), .DEN_W(4), .PAY_W($bits(chan_type))) u_div_off (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (d2_vld),
      .in_num    (d2_off),
      .in_den    (block_stride_ff),
      .in_pay    (d3_in_pay),
      .out_valid (d3_vld),
      .out_quo   (d3_off_row),
      .out_rem   (d3_off_col),
      .out_pay   (d3_pay)
   );

   // ---------------- stage C: spatial coords and operand select ----------------
   req_type             d3_req;
   logic [OW-1:0]       w2;
   logic [OW-1:0]       h2;
   rag_pkg::horner_type deep_in;
   rag_pkg::horner_type spat_in;
   rag_pkg::horner_type deep_ff;
   rag_pkg::horner_type spat_ff;
   logic                c_vld_ff;
   logic                c_bad_ff;

   assign d3_req = d3_pay.prev.req;
   assign w2 = OW'(d3_req.i) * OW'(block_stride_ff) + OW'(d3_off_col);
   assign h2 = OW'(d3_req.j) * OW'(block_stride_ff) + OW'(d3_off_row);

   always_comb begin
      if (channels_last_ff) begin
         // NHWC: k + C*(i + W*(j + H*b)), c2 + oc*(w2 + Ws*(h2 + Hs*b))
         deep_in = '{a0: OW'(d3_req.k), m0: OW'(channel_count_ff),
                     a1: OW'(d3_req.i), m1: OW'(width_count_ff),
                     a2: OW'(d3_req.j), m2: OW'(height_count_ff),
                     a3: OW'(d3_req.b)};
         spat_in = '{a0: OW'(d3_pay.c2), m0: OW'(d3_pay.prev.oc),
                     a1: w2, m1: OW'(ws_ff),
                     a2: h2, m2: OW'(hs_ff),
                     a3: OW'(d3_req.b)};
      end else begin
         // NCHW: i + W*(j + H*(k + C*b)), w2 + Ws*(h2 + Hs*(c2 + oc*b))
         deep_in = '{a0: OW'(d3_req.i), m0: OW'(width_count_ff),
                     a1: OW'(d3_req.j), m1: OW'(height_count_ff),
                     a2: OW'(d3_req.k), m2: OW'(channel_count_ff),
                     a3: OW'(d3_req.b)};
         spat_in = '{a0: w2, m0: OW'(ws_ff),
                     a1: h2, m1: OW'(hs_ff),
                     a2: OW'(d3_pay.c2), m2: OW'(d3_pay.prev.oc),
                     a3: OW'(d3_req.b)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (advance) begin
         c_vld_ff <= d3_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         deep_ff  <= deep_in;
         spat_ff  <= spat_in;
         c_bad_ff <= d3_req.bad;
      end
   end

   // ---------------- multiply chains ----------------
   logic [AW-1:0] deep_addr;
   logic [AW-1:0] spat_addr;
   logic          mac_vld_ff [3];
   logic          mac_bad_ff [3];

   rag_mac u_mac_deep (
      .clock      (clock),
      .advance    (advance),
      .in_opnd    (deep_ff),
      .out_result (deep_addr)
   );

   rag_mac u_mac_spat (
      .clock      (clock),
      .advance    (advance),
      .in_opnd    (spat_ff),
      .out_result (spat_addr)
   );

   // valid and reject flag ride alongside the multiply stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 3; n++) begin
            mac_vld_ff[n] <= 1'b0;
         end
      end else if (advance) begin
         mac_vld_ff[0] <= c_vld_ff;
         for (int n = 1; n < 3; n++) begin
            mac_vld_ff[n] <= mac_vld_ff[n-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mac_bad_ff[0] <= c_bad_ff;
         for (int n = 1; n < 3; n++) begin
            mac_bad_ff[n] <= mac_bad_ff[n-1];
         end
      end
   end

   // ---------------- output register ----------------
   logic [AW-1:0] rsp_read_ff;
   logic [AW-1:0] rsp_write_ff;
   logic          rsp_bad_ff;
   logic [AW-1:0] rd_in;
   logic [AW-1:0] wr_in;

   always_comb begin
      if (mac_bad_ff[2]) begin
         rd_in = '0;
         wr_in = '0;
      end else if (direction_ff) begin
         rd_in = deep_addr;
         wr_in = spat_addr;
      end else begin
         rd_in = spat_addr;
         wr_in = deep_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= mac_vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_read_ff  <= rd_in;
         rsp_write_ff <= wr_in;
         rsp_bad_ff   <= mac_bad_ff[2];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_write_ff, rsp_read_ff};
   assign rsp_tuser  = rsp_bad_ff;

   // ---------------- assertions ----------------
   // rejected requests carry zero addresses
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("rejected request with nonzero address");

   // reset empties every stage
   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // no skid buffer: a held response must stall intake
   a_stall_intake: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while response stalled");

endmodule

@@ sim/reorg_move_checker.sv @@
module reorg_move_checker #(
   parameter int MAX_CHANNELS = 4096,
   parameter int MAX_SIDE     = 1024,
   parameter int MAX_BATCH    = 16,
   parameter int MAX_STRIDE   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_addr,
   input  logic [12:0] csr_wdata,
   output int          fail_count,
   output int          outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [4:0]  batch_count;
      logic [12:0] channel_count;
      logic [10:0] height_count;
      logic [10:0] width_count;
      logic [3:0]  block_stride;
      logic        direction;
      logic        channels_last;
   } layout_type;

   typedef struct {
      logic [rag_pkg::ADDR_W-1:0] read_addr;
      logic [rag_pkg::ADDR_W-1:0] write_addr;
      logic                       bad;
   } move_type;

   layout_type layout;
   move_type   move_q[$];
   int         errors = 0;

   // Flat deep and spatial indexes of one element, swapped by direction.
   function automatic move_type predict_move(layout_type cfg, logic [3:0] b, logic [11:0] k,
                                             logic [9:0] j, logic [9:0] i);
      move_type m;
      longint unsigned s, sq, oc, c2, off, w2, h2, deep, spat, bc, cc, hc, wc;
      s  = cfg.block_stride;
      bc = cfg.batch_count;
      cc = cfg.channel_count;
      hc = cfg.height_count;
      wc = cfg.width_count;
      sq = s * s;
      oc = (sq != 0) ? cc / sq : 0;
      m.bad = (oc == 0) || (b >= bc) || (k >= cc) || (j >= hc) || (i >= wc) ||
              (bc > MAX_BATCH) || (cc > MAX_CHANNELS) || (hc > MAX_SIDE) ||
              (wc > MAX_SIDE) || (s > MAX_STRIDE);
      m.read_addr  = '0;
      m.write_addr = '0;
      if (!m.bad) begin
         c2  = k % oc;
         off = k / oc;
         w2  = i * s + off % s;
         h2  = j * s + off / s;
         if (cfg.channels_last) begin
            deep = k + cc * (i + wc * (j + hc * b));
            spat = c2 + oc * (w2 + wc * s * (h2 + hc * s * b));
         end else begin
            deep = i + wc * (j + hc * (k + cc * b));
            spat = w2 + wc * s * (h2 + hc * s * (c2 + oc * b));
         end
         if (cfg.direction) begin
            m.read_addr  = deep[rag_pkg::ADDR_W-1:0];
            m.write_addr = spat[rag_pkg::ADDR_W-1:0];
         end else begin
            m.read_addr  = spat[rag_pkg::ADDR_W-1:0];
            m.write_addr = deep[rag_pkg::ADDR_W-1:0];
         end
      end
      return m;
   endfunction

   always @(posedge clock) begin
      move_type want;
      if (reset) begin
         layout = '{5'd1, 13'd4, 11'd1, 11'd1, 4'd2, 1'b0, 1'b0};
         move_q.delete();
      end else begin
         if (csr_wr_en) begin
            unique case (rag_pkg::reg_index_type'(csr_addr))
               rag_pkg::REG_BATCH_COUNT:   layout.batch_count   = csr_wdata[4:0];
               rag_pkg::REG_CHANNEL_COUNT: layout.channel_count = csr_wdata[12:0];
               rag_pkg::REG_HEIGHT_COUNT:  layout.height_count  = csr_wdata[10:0];
               rag_pkg::REG_WIDTH_COUNT:   layout.width_count   = csr_wdata[10:0];
               rag_pkg::REG_BLOCK_STRIDE:  layout.block_stride  = csr_wdata[3:0];
               rag_pkg::REG_DIRECTION:     layout.direction     = csr_wdata[0];
               rag_pkg::REG_CHANNELS_LAST: layout.channels_last = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            move_q.push_back(predict_move(layout, req_tdata[3:0], req_tdata[15:4],
                                          req_tdata[25:16], req_tdata[35:26]));
         if (rsp_tvalid && rsp_tready) begin
            if (move_q.size() == 0) begin
               $error("response with no request outstanding");
               errors++;
            end else begin
               want = move_q.pop_front();
               if (rsp_tdata[35:0] !== want.read_addr) begin
                  $error("read_address: expected %h, got %h", want.read_addr,
                         rsp_tdata[35:0]);
                  errors++;
               end
               if (rsp_tdata[71:36] !== want.write_addr) begin
                  $error("write_address: expected %h, got %h", want.write_addr,
                         rsp_tdata[71:36]);
                  errors++;
               end
               if (rsp_tuser !== want.bad) begin
                  $error("bad_request: expected %b, got %b", want.bad, rsp_tuser);
                  errors++;
               end
            end
         end
      end
      fail_count  <= errors;
      outstanding <= move_q.size();
   end

endmodule

@@ sim/tb_top.sv @@
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQUEST_TARGET = 1750;
   localparam int STALL_LIMIT    = 2000;  // cycles with no accept of any kind
   localparam int DRAIN_CYCLES   = 60;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en  = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [12:0] csr_wdata  = '0;

   int fail_count;
   int outstanding;

   // idle odds in percent, changed as the run moves through its phases
   int unsigned send_idle_pct = 29;
   int unsigned recv_idle_pct = 48;

   // current register contents, used to aim request indexes at the tensor
   int unsigned cur_batch   = 1;
   int unsigned cur_channel = 4;
   int unsigned cur_height  = 1;
   int unsigned cur_width   = 1;

   int unsigned requests_sent = 0;
   int unsigned quiet_cycles  = 0;

   reorg_address_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   reorg_move_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog: any request, response or register write counts as progress
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // One request; random idle cycles ahead of it, valid held until accepted.
   task automatic send_request(input logic [3:0] b, input logic [11:0] k,
                               input logic [9:0] j, input logic [9:0] i);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, i, j, k, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
      // idle mode follows progress: receiver-heavy, sender-heavy, then none
      if (requests_sent < REQUEST_TARGET / 3) begin
         send_idle_pct = 29;
         recv_idle_pct = 48;
      end else if (requests_sent < 2 * REQUEST_TARGET / 3) begin
         send_idle_pct = 48;
         recv_idle_pct = 29;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   // drop valid and wait for every predicted response to come back
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input rag_pkg::reg_index_type idx, input int unsigned value);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value[12:0];
      @(posedge clock);
   endtask

   // Block is idle here: all registers rewritten back to back.
   task automatic apply_layout(input int unsigned bc, input int unsigned cc,
                               input int unsigned hc, input int unsigned wc,
                               input int unsigned s, input bit dir, input bit clast);
      drain();
      write_reg(rag_pkg::REG_BATCH_COUNT, bc);
      write_reg(rag_pkg::REG_CHANNEL_COUNT, cc);
      write_reg(rag_pkg::REG_HEIGHT_COUNT, hc);
      write_reg(rag_pkg::REG_WIDTH_COUNT, wc);
      write_reg(rag_pkg::REG_BLOCK_STRIDE, s);
      write_reg(rag_pkg::REG_DIRECTION, dir);
      write_reg(rag_pkg::REG_CHANNELS_LAST, clast);
      csr_wr_en <= 1'b0;
      cur_batch   = bc;
      cur_channel = cc;
      cur_height  = hc;
      cur_width   = wc;
   endtask

   // Size register: mostly in range, sometimes at an end, sometimes illegal
   // (zero or above the limit, up to the full register width).
   function automatic int unsigned pick_count(int unsigned hi, int unsigned reg_max);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 1;
      if (r < 20) return hi;
      if (r < 23) return $urandom_range(reg_max, hi + 1);
      if (r < 25) return 0;
      return $urandom_range(hi, 1);
   endfunction

   // Index into a dimension: mostly inside it, with edges, one-past and noise.
   function automatic int unsigned pick_index(int unsigned count, int unsigned field_max);
      int unsigned lim, r;
      lim = (count > field_max + 1) ? field_max + 1 : count;
      r   = $urandom_range(99);
      if (lim == 0 || r < 4) return $urandom_range(field_max, 0);
      if (r < 8) return (count > field_max) ? field_max : count;
      if (r < 20) return lim - 1;
      if (r < 28) return 0;
      return $urandom_range(lim - 1, 0);
   endfunction

   task automatic random_phase;
      int unsigned s, sq, cc, bc, hc, wc, n, r;
      r = $urandom_range(99);
      if (r < 10)      s = 1;
      else if (r < 20) s = 8;
      else if (r < 23) s = $urandom_range(15, 9);
      else if (r < 25) s = 0;
      else             s = $urandom_range(8, 1);
      sq = s * s;
      // channel count a whole multiple of stride squared about half the time
      if (sq >= 1 && sq <= 64 && $urandom_range(1) == 1)
         cc = sq * $urandom_range(4096 / sq, 1);
      else
         cc = pick_count(4096, 8191);
      bc = pick_count(16, 31);
      hc = pick_count(1024, 2047);
      wc = pick_count(1024, 2047);
      apply_layout(bc, cc, hc, wc, s, 1'($urandom_range(1)), 1'($urandom_range(1)));
      n = $urandom_range(120, 20);
      repeat (n)
         send_request(4'(pick_index(cur_batch, 15)), 12'(pick_index(cur_channel, 4095)),
                      10'(pick_index(cur_height, 1023)), 10'(pick_index(cur_width, 1023)));
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset layout: one output channel, single pixel, stride 2
      send_request(0, 0, 0, 0);
      send_request(0, 3, 0, 0);
      send_request(1, 0, 0, 0);   // batch one past the end
      send_request(0, 4, 0, 0);   // channel one past the end
      send_request(0, 0, 1, 0);   // row one past the end
      send_request(0, 0, 0, 1);   // column one past the end

      // largest legal tensor, stride 1, deep-to-spatial, interleaved
      apply_layout(16, 4096, 1024, 1024, 1, 1'b1, 1'b1);
      send_request(15, 4095, 1023, 1023);
      send_request(0, 0, 0, 0);
      send_request(15, 4095, 1023, 0);

      // largest stride, planar, spatial-to-deep; addresses reach the top of the 36-bit range
      apply_layout(16, 4096, 1024, 1024, 8, 1'b0, 1'b0);
      send_request(15, 4095, 1023, 1023);
      send_request(7, 63, 5, 9);
      send_request(0, 64, 0, 0);

      // channels not a multiple of stride squared: offset reaches 9
      apply_layout(3, 100, 5, 7, 3, 1'b1, 1'b0);
      send_request(2, 99, 4, 6);
      send_request(1, 50, 2, 3);

      // fewer channels than stride squared: no output channels
      apply_layout(2, 3, 4, 4, 2, 1'b0, 1'b1);
      send_request(0, 0, 0, 0);

      // zero stride
      apply_layout(2, 8, 4, 4, 0, 1'b1, 1'b1);
      send_request(0, 1, 1, 1);

      // every size and stride register at its all-ones value, above the limits
      apply_layout(31, 8191, 2047, 2047, 15, 1'b0, 1'b0);
      send_request(0, 0, 0, 0);

      // zero sizes, stride one past the limit
      apply_layout(0, 0, 0, 0, 9, 1'b1, 1'b0);
      send_request(0, 0, 0, 0);

      // sizes one past the limit
      apply_layout(17, 4097, 1025, 1025, 2, 1'b0, 1'b1);
      send_request(0, 0, 0, 0);

      while (requests_sent < REQUEST_TARGET) random_phase();

      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
